@@ rtl/tppu_pkg.sv @@
// shared types, constants and microcode table of the trapezoid positioning profiler
// no dependencies; imported by every other module of the block

package tppu_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_ACCEL_STEP   = 3'd0;
   localparam logic [2:0] REG_DECEL_STEP   = 3'd1;
   localparam logic [2:0] REG_ACCEL_TICKS  = 3'd2;
   localparam logic [2:0] REG_BRAKE_FACTOR = 3'd3;
   localparam logic [2:0] REG_BRAKE_SHIFT  = 3'd4;

   // input item opcodes
   localparam logic OPC_TICK  = 1'b0;
   localparam logic OPC_START = 1'b1;

   localparam int STEP_W = 3;
   typedef logic [STEP_W-1:0] step_type;

   // datapath micro-operations
   typedef enum logic [2:0] {
      UOP_WAIT,
      UOP_EVAL,
      UOP_MUL_REM,
      UOP_MUL_SQ,
      UOP_TEST1,
      UOP_TEST2,
      UOP_EMIT
   } uop_type;

   // jump conditions of the sequencer
   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_NO_ITEM,
      COND_FINISH,
      COND_NO_BRAKE
   } cond_type;

   typedef struct packed {
      uop_type  uop;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   // status flags from the datapath used for jumps
   typedef struct packed {
      logic finish;
      logic no_brake;
   } status_type;

   typedef struct packed {
      logic       start_refused;
      logic       done_pulse;
      logic       braking;
      logic       moving;
      logic [7:0] speed_command;
   } result_type;

   // program labels
   localparam step_type STEP_WAIT = 3'd0;
   localparam step_type STEP_EMIT = 3'd7;

   // microcode program, one control word per step
   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type w;
      case (step)
         3'd0:    w = '{uop: UOP_WAIT,    cond: COND_NO_ITEM,  target: STEP_WAIT};
         3'd1:    w = '{uop: UOP_EVAL,    cond: COND_FINISH,   target: STEP_EMIT};
         3'd2:    w = '{uop: UOP_MUL_REM, cond: COND_NEXT,     target: STEP_WAIT};
         3'd3:    w = '{uop: UOP_MUL_SQ,  cond: COND_NEXT,     target: STEP_WAIT};
         3'd4:    w = '{uop: UOP_TEST1,   cond: COND_NO_BRAKE, target: STEP_EMIT};
         3'd5:    w = '{uop: UOP_MUL_SQ,  cond: COND_NEXT,     target: STEP_WAIT};
         3'd6:    w = '{uop: UOP_TEST2,   cond: COND_NEXT,     target: STEP_WAIT};
         3'd7:    w = '{uop: UOP_EMIT,    cond: COND_ALWAYS,   target: STEP_WAIT};
         default: w = '{uop: UOP_WAIT,    cond: COND_ALWAYS,   target: STEP_WAIT};
      endcase
      return w;
   endfunction

endpackage

@@ rtl/tppu_sequencer.sv @@
// microcode sequencer: step counter, program table and conditional jumps
// depends on tppu_pkg

module tppu_sequencer
   import tppu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          item_accept,
   input  status_type    status,
   output ctrl_word_type ctrl
);

   step_type step_ff, step_in;
   logic     take_jump;

   // current control word
   assign ctrl = ucode_rom(step_ff);

   // jump condition select
   always_comb begin
      case (ctrl.cond)
         COND_NEXT:     take_jump = 1'b0;
         COND_ALWAYS:   take_jump = 1'b1;
         COND_NO_ITEM:  take_jump = !item_accept;
         COND_FINISH:   take_jump = status.finish;
         COND_NO_BRAKE: take_jump = status.no_brake;
         default:       take_jump = 1'b1;
      endcase
      step_in = take_jump ? ctrl.target : step_type'(step_ff + 1'b1);
   end

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

@@ rtl/tppu_datapath.sv @@
// profiler datapath: configuration, axis state, shared multiplier and braking compare
// depends on tppu_pkg; driven by the control word of tppu_sequencer

module tppu_datapath
   import tppu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wen,
   input  logic [2:0]    csr_index,
   input  logic [11:0]   csr_wdata,
   input  logic          item_accept,
   input  logic          item_opcode,
   input  logic [15:0]   item_position_now,
   input  logic [15:0]   item_target_position,
   input  logic [7:0]    item_top_speed,
   input  ctrl_word_type ctrl,
   output status_type    status,
   output result_type    result
);

   // configuration
   logic [7:0]  accel_step_ff, decel_step_ff, accel_ticks_ff;
   logic [11:0] brake_factor_ff;
   logic [3:0]  brake_shift_ff;

   // latched item
   logic        opcode_ff;
   logic [15:0] pos_ff, tgt_ff;
   logic [7:0]  top_ff;

   // axis state
   logic [7:0]  speed_ff, speed_in;
   logic [15:0] goal_ff, goal_in;
   logic        fwd_ff, fwd_in;
   logic        brake_ff, brake_in;
   logic [7:0]  prescale_ff, prescale_in;
   logic        active_ff, active_in;
   logic        done_ff, done_in;
   logic        refused_ff, refused_in;

   // work registers
   logic [15:0] rem_ff, rem_in;
   logic [27:0] rb_ff, rb_in;
   logic [15:0] sq_ff, sq_in;

   logic [16:0] diff_fwd, diff_rev;
   logic [15:0] rem_now;
   logic [15:0] mul_a, mul_b;
   logic [31:0] mul_p;
   logic [15:0] sq_shifted;
   logic [27:0] sq_scaled;
   logic        brake_hit;
   logic [8:0]  accel_sum;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         accel_step_ff   <= 8'd1;
         decel_step_ff   <= 8'd1;
         accel_ticks_ff  <= 8'd1;
         brake_factor_ff <= 12'd256;
         brake_shift_ff  <= 4'd0;
      end else if (csr_wen) begin
         case (csr_index)
            REG_ACCEL_STEP:   accel_step_ff   <= csr_wdata[7:0];
            REG_DECEL_STEP:   decel_step_ff   <= csr_wdata[7:0];
            REG_ACCEL_TICKS:  accel_ticks_ff  <= csr_wdata[7:0];
            REG_BRAKE_FACTOR: brake_factor_ff <= csr_wdata;
            REG_BRAKE_SHIFT:  brake_shift_ff  <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (item_accept) begin
         opcode_ff <= item_opcode;
         pos_ff    <= item_position_now;
         tgt_ff    <= item_target_position;
         top_ff    <= item_top_speed;
      end
   end

   // remaining distance in the direction of travel
   always_comb begin
      diff_fwd = {goal_ff[15], goal_ff} - {pos_ff[15], pos_ff};
      diff_rev = {pos_ff[15], pos_ff} - {goal_ff[15], goal_ff};
      if (fwd_ff && ($signed(goal_ff) > $signed(pos_ff))) begin
         rem_now = diff_fwd[15:0];
      end else if (!fwd_ff && ($signed(goal_ff) < $signed(pos_ff))) begin
         rem_now = diff_rev[15:0];
      end else begin
         rem_now = 16'd0;
      end
   end

   // shared multiplier
   always_comb begin
      if (ctrl.uop == UOP_MUL_REM) begin
         mul_a = rem_ff;
         mul_b = {4'd0, brake_factor_ff};
      end else begin
         mul_a = {8'd0, speed_ff};
         mul_b = {8'd0, speed_ff};
      end
      mul_p = mul_a * mul_b;
   end

   // braking test: (sq >> shift) << 8 against rem * factor
   assign sq_shifted = sq_ff >> brake_shift_ff;
   assign sq_scaled  = {4'd0, sq_shifted, 8'd0};
   assign brake_hit  = sq_scaled >= rb_ff;
   assign accel_sum  = {1'b0, speed_ff} + {1'b0, accel_step_ff};

   assign status.finish   = (opcode_ff == OPC_START) || !active_ff || (rem_now == 16'd0);
   assign status.no_brake = !brake_hit;

   // micro-operation execution
   always_comb begin
      speed_in    = speed_ff;
      goal_in     = goal_ff;
      fwd_in      = fwd_ff;
      brake_in    = brake_ff;
      prescale_in = prescale_ff;
      active_in   = active_ff;
      done_in     = done_ff;
      refused_in  = refused_ff;
      rem_in      = rem_ff;
      rb_in       = rb_ff;
      sq_in       = sq_ff;
      case (ctrl.uop)
         UOP_EVAL: begin
            done_in    = 1'b0;
            refused_in = 1'b0;
            rem_in     = rem_now;
            if (opcode_ff == OPC_START) begin
               if (speed_ff != 8'd0) begin
                  refused_in = 1'b1;
               end else if (tgt_ff != pos_ff) begin
                  goal_in   = tgt_ff;
                  fwd_in    = $signed(tgt_ff) > $signed(pos_ff);
                  active_in = 1'b1;
                  brake_in  = 1'b0;
               end
            end else if (active_ff && (rem_now == 16'd0)) begin
               // goal reached or passed
               speed_in  = 8'd0;
               active_in = 1'b0;
               brake_in  = 1'b0;
               done_in   = 1'b1;
            end
         end
         UOP_MUL_REM: rb_in = mul_p[27:0];
         UOP_MUL_SQ:  sq_in = mul_p[15:0];
         UOP_TEST1: begin
            if (brake_hit) begin
               brake_in = 1'b1;
               if (speed_ff > decel_step_ff) begin
                  speed_in = speed_ff - decel_step_ff;
               end
            end else if ((speed_ff < top_ff) && !brake_ff) begin
               if (prescale_ff < accel_ticks_ff) begin
                  prescale_in = prescale_ff + 8'd1;
               end else begin
                  prescale_in = 8'd1;
                  speed_in    = accel_sum[8] ? 8'hFF : accel_sum[7:0];
               end
            end else begin
               prescale_in = 8'd1;
            end
         end
         UOP_TEST2: begin
            if (brake_hit && (speed_ff > decel_step_ff)) begin
               speed_in = speed_ff - decel_step_ff;
            end
         end
         default: ;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff    <= 8'd0;
         goal_ff     <= 16'd0;
         fwd_ff      <= 1'b0;
         brake_ff    <= 1'b0;
         prescale_ff <= 8'd1;
         active_ff   <= 1'b0;
         done_ff     <= 1'b0;
         refused_ff  <= 1'b0;
      end else begin
         speed_ff    <= speed_in;
         goal_ff     <= goal_in;
         fwd_ff      <= fwd_in;
         brake_ff    <= brake_in;
         prescale_ff <= prescale_in;
         active_ff   <= active_in;
         done_ff     <= done_in;
         refused_ff  <= refused_in;
      end
   end

   // work registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      rb_ff  <= rb_in;
      sq_ff  <= sq_in;
   end

   assign result.speed_command = speed_ff;
   assign result.moving        = active_ff;
   assign result.braking       = brake_ff;
   assign result.done_pulse    = done_ff;
   assign result.start_refused = refused_ff;

endmodule

@@ rtl/trapezoid_positioning_profiler_unit.sv @@
// top level of the trapezoid positioning profiler: stream ports, result register
// depends on tppu_pkg, tppu_sequencer and tppu_datapath
//
// channel   ports                         payload
// req       req_tvalid/tready/tdata/tuser opcode, position_now, target_position, top_speed
// rsp       rsp_tvalid/tready/tdata       speed_command, moving, braking, done_pulse, ...
// csr       csr_wen/index/wdata           accel_step .. brake_shift, no read-back
//
// items are worked one at a time by the microcode program; a start, an idle tick
// or a completing tick runs the wait, evaluate and emit steps, an accelerating or
// cruising tick adds the distance and square products and the first braking test,
// and a braking tick adds a second square and test, on the single shared multiplier.
// the result sits in an output register; a new item is taken once that register is
// free or being emptied. reset is synchronous and brings the program to its wait step.

module trapezoid_positioning_profiler_unit
   import tppu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] position_now, [31:16] target_position, [39:32] top_speed
   input  logic [39:0] req_tdata,
   // [0] opcode
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] speed_command, [8] moving, [9] braking, [10] done_pulse,
   // [11] start_refused, [15:12] zero
   output logic [15:0] rsp_tdata,
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_wdata
);

   ctrl_word_type ctrl;
   status_type    status;
   result_type    result;
   logic          item_accept;
   logic          rsp_valid_ff, rsp_valid_in;
   result_type    rsp_data_ff;

   // input handshake
   assign req_tready  = (ctrl.uop == UOP_WAIT) && (!rsp_valid_ff || rsp_tready);
   assign item_accept = req_tvalid && req_tready;

   tppu_sequencer u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .item_accept (item_accept),
      .status      (status),
      .ctrl        (ctrl)
   );

   tppu_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .csr_wen              (csr_wen),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .item_accept          (item_accept),
      .item_opcode          (req_tuser),
      .item_position_now    (req_tdata[15:0]),
      .item_target_position (req_tdata[31:16]),
      .item_top_speed       (req_tdata[39:32]),
      .ctrl                 (ctrl),
      .status               (status),
      .result               (result)
   );

   // result register
   always_comb begin
      if (ctrl.uop == UOP_EMIT) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.uop == UOP_EMIT) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_data_ff};

endmodule

@@ sim/trapezoid_positioning_profiler_unit_tb.sv @@
// self-checking testbench for trapezoid_positioning_profiler_unit: start and tick items
// go in over the req stream, each speed command is checked against an in-bench profile
// predictor; depends on tppu_pkg and the rtl top level
`timescale 1ns / 100ps

// profile predictor and the queue of speed commands it expects
class speed_command_board;
   // register copies
   int unsigned accel_step   = 1;
   int unsigned decel_step   = 1;
   int unsigned accel_ticks  = 1;
   int unsigned brake_factor = 256;
   int unsigned brake_shift  = 0;

   // profiler state
   logic [7:0]        speed    = 8'd0;
   logic signed [15:0] goal    = 16'sd0;
   bit                forward  = 1'b0;
   bit                braking  = 1'b0;
   logic [7:0]        prescale = 8'd1;
   bit                active   = 1'b0;

   tppu_pkg::result_type pending_commands[$];

   int failures  = 0;
   int n_items   = 0;
   int n_results = 0;
   int n_done    = 0;
   int n_refused = 0;
   int n_brake   = 0;

   function void set_reg(logic [2:0] index, int unsigned value);
      case (index)
         tppu_pkg::REG_ACCEL_STEP:   accel_step   = value & 32'hFF;
         tppu_pkg::REG_DECEL_STEP:   decel_step   = value & 32'hFF;
         tppu_pkg::REG_ACCEL_TICKS:  accel_ticks  = value & 32'hFF;
         tppu_pkg::REG_BRAKE_FACTOR: brake_factor = value & 32'hFFF;
         tppu_pkg::REG_BRAKE_SHIFT:  brake_shift  = value & 32'hF;
         default: ;
      endcase
   endfunction

   // exact test of (v*v >> shift) >= rem * factor / 256
   function bit brake_needed(int unsigned v, int unsigned rem);
      longint unsigned sq;
      sq = (longint'(v) * longint'(v)) >> brake_shift;
      return (sq << 8) >= longint'(rem) * longint'(brake_factor);
   endfunction

   // advance the predicted state by one accepted item and queue its command
   function void note_item(logic op, logic signed [15:0] pos, logic signed [15:0] tgt,
                           logic [7:0] top);
      tppu_pkg::result_type want;
      int unsigned rem;
      int unsigned v;
      bit done;
      bit refused;
      done    = 1'b0;
      refused = 1'b0;
      n_items++;
      if (op == tppu_pkg::OPC_START) begin
         if (speed != 8'd0) begin
            refused = 1'b1;
         end else if (tgt != pos) begin
            goal    = tgt;
            forward = (tgt > pos);
            active  = 1'b1;
            braking = 1'b0;
         end
      end else if (active) begin
         rem = 0;
         if (forward && goal > pos) rem = int'(goal) - int'(pos);
         else if (!forward && goal < pos) rem = int'(pos) - int'(goal);
         if (rem == 0) begin
            // goal reached or passed
            speed   = 8'd0;
            active  = 1'b0;
            braking = 1'b0;
            done    = 1'b1;
         end else begin
            v = speed;
            if (brake_needed(v, rem)) begin
               braking = 1'b1;
               if (v > decel_step) v = v - decel_step;
               if (brake_needed(v, rem) && v > decel_step) v = v - decel_step;
            end else if (v < top && !braking) begin
               if (prescale < accel_ticks) begin
                  prescale = prescale + 8'd1;
               end else begin
                  prescale = 8'd1;
                  v = v + accel_step;
                  if (v > 255) v = 255;
               end
            end else begin
               prescale = 8'd1;
            end
            speed = v[7:0];
         end
      end
      if (done) n_done++;
      if (refused) n_refused++;
      if (braking) n_brake++;
      want.speed_command = speed;
      want.moving        = active;
      want.braking       = braking;
      want.done_pulse    = done;
      want.start_refused = refused;
      pending_commands.push_back(want);
   endfunction

   // compare one accepted rsp item with the oldest expected command
   function void match_response(logic [15:0] data);
      tppu_pkg::result_type got;
      tppu_pkg::result_type want;
      got = data[11:0];
      n_results++;
      if (pending_commands.size() == 0) begin
         $error("rsp item 0x%h with no speed command expected", data);
         failures++;
         return;
      end
      want = pending_commands.pop_front();
      if (got.speed_command !== want.speed_command) begin
         $error("speed_command: expected %0d, actual %0d", want.speed_command,
                got.speed_command);
         failures++;
      end
      if (got.moving !== want.moving) begin
         $error("moving: expected %0d, actual %0d", want.moving, got.moving);
         failures++;
      end
      if (got.braking !== want.braking) begin
         $error("braking: expected %0d, actual %0d", want.braking, got.braking);
         failures++;
      end
      if (got.done_pulse !== want.done_pulse) begin
         $error("done_pulse: expected %0d, actual %0d", want.done_pulse, got.done_pulse);
         failures++;
      end
      if (got.start_refused !== want.start_refused) begin
         $error("start_refused: expected %0d, actual %0d", want.start_refused,
                got.start_refused);
         failures++;
      end
   endfunction
endclass

module trapezoid_positioning_profiler_unit_tb;
   import tppu_pkg::*;

   localparam int N_PHASES    = 7;
   localparam int PHASE_ITEMS = 65;
   localparam int MOVE_TICKS  = 60;
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_PHASE  = 4;
   localparam int PAUSE_PHASE = 5;
   localparam int CYCLE_LIMIT = 400000;

   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_wen    = 1'b0;
   logic [2:0]  csr_index  = '0;
   logic [11:0] csr_wdata  = '0;

   speed_command_board sb = new();

   logic signed [15:0] axis_pos = 16'sd0;
   int  burst_left  = 0;
   bit  steady      = 1'b0;
   int  hold_asked  = 0;
   int  hold_served = 0;
   bit  hold_active = 1'b0;
   int  cycle_count = 0;

   trapezoid_positioning_profiler_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.match_response(rsp_tdata);
   end

   // receiver: stretches of random stall patterns, plus a long hold-off on request
   initial begin
      rx_mode_type mode;
      int stretch;
      forever begin
         if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_active = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_active = 1'b0;
         end else begin
            mode    = rx_mode_type'($urandom_range(0, 3));
            stretch = $urandom_range(4, 48);
            repeat (stretch) begin
               case (mode)
                  RX_OPEN:   rsp_tready <= 1'b1;
                  RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
                  RX_SPARSE: rsp_tready <= ($urandom_range(0, 5) == 0);
                  default:   rsp_tready <= ($urandom_range(0, 3) != 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   function automatic logic [15:0] rand16();
      return 16'($urandom);
   endfunction

   function automatic logic [7:0] rand8();
      return 8'($urandom);
   endfunction

   function automatic logic signed [15:0] clamp16(input int p);
      if (p > 32767) return 16'h7FFF;
      if (p < -32768) return 16'h8000;
      return p[15:0];
   endfunction

   // offer one item and wait for its handshake; bursts with random gaps between them
   task automatic send_item(input logic op, input logic [15:0] pos, input logic [15:0] tgt,
                            input logic [7:0] top);
      int gap;
      if (!steady && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left != 0) burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {top, tgt, pos};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_item(op, pos, tgt, top);
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_for_commands();
      while (sb.pending_commands.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input int unsigned value);
      csr_wen   <= 1'b1;
      csr_index <= index;
      csr_wdata <= 12'(value);
      @(posedge clock);
      sb.set_reg(index, value);
   endtask

   // register setting of one phase; the first four are fixed corners
   task automatic load_setting(input int ph);
      int unsigned a_step, d_step, a_ticks, factor, shift;
      case (ph)
         0: begin a_step = 1;   d_step = 1;   a_ticks = 1;   factor = 256;  shift = 0;  end
         1: begin a_step = 255; d_step = 255; a_ticks = 255; factor = 4095; shift = 15; end
         2: begin a_step = 200; d_step = 0;   a_ticks = 0;   factor = 4095; shift = 15; end
         3: begin a_step = 0;   d_step = 3;   a_ticks = 2;   factor = 0;    shift = 4;  end
         default: begin
            a_step  = $urandom_range(1, 48);
            d_step  = $urandom_range(1, 48);
            a_ticks = $urandom_range(1, 4);
            factor  = $urandom_range(0, 4095);
            shift   = $urandom_range(0, 6);
         end
      endcase
      write_reg(REG_ACCEL_STEP, a_step);
      write_reg(REG_DECEL_STEP, d_step);
      write_reg(REG_ACCEL_TICKS, a_ticks);
      write_reg(REG_BRAKE_FACTOR, factor);
      write_reg(REG_BRAKE_SHIFT, shift);
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   // one positioning move: start, then ticks from a crude axis that follows the command
   task automatic run_move();
      int span, p, travel, div, n, pick;
      logic [7:0] top;
      div  = $urandom_range(0, 2);
      span = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 700);
      p    = $urandom_range(0, 1) ? int'(axis_pos) + span : int'(axis_pos) - span;
      top  = ($urandom_range(0, 7) == 0) ? rand8() : 8'($urandom_range(16, 255));
      send_item(OPC_START, axis_pos, clamp16(p), rand8());
      n = 0;
      while (sb.active && n < MOVE_TICKS) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            // start in the middle of a move
            send_item(OPC_START, axis_pos, rand16(), rand8());
         end else begin
            if (pick == 1) axis_pos = rand16();
            if (pick == 2) top = rand8();
            travel = int'(sb.speed) >> div;
            if (sb.speed != 8'd0 && travel == 0) travel = 1;
            travel = travel + $urandom_range(0, 2) - 1;
            axis_pos = clamp16(int'(axis_pos) + (sb.forward ? travel : -travel));
            send_item(OPC_TICK, axis_pos, rand16(), top);
         end
         n++;
      end
      // a stuck move is closed by jumping onto the goal
      if (sb.active) begin
         axis_pos = sb.goal;
         send_item(OPC_TICK, axis_pos, rand16(), top);
      end
   endtask

   initial begin
      int phase_end;
      bit paused;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed items at reset settings
      send_item(OPC_TICK,  16'h8000, 16'h7FFF, 8'hFF);   // idle tick
      send_item(OPC_START, 16'd100, 16'd100, rand8());  // start at current position
      send_item(OPC_START, 16'd0, 16'd3, rand8());
      send_item(OPC_TICK,  16'd0, rand16(), 8'hFF);
      send_item(OPC_TICK,  16'd1, rand16(), 8'hFF);
      send_item(OPC_TICK,  16'd1, rand16(), 8'hFF);     // braking begins
      send_item(OPC_START, 16'd1, 16'hFE0C, rand8());   // refused while moving
      send_item(OPC_TICK,  16'd2, rand16(), 8'hFF);     // speed held at one step
      send_item(OPC_TICK,  16'd3, rand16(), 8'hFF);     // goal reached
      send_item(OPC_START, 16'h7FFF, 16'h8000, rand8()); // longest move, backward
      send_item(OPC_TICK,  16'h7FFF, rand16(), 8'hFF);
      send_item(OPC_TICK,  16'h7FFF, rand16(), 8'hFF);
      send_item(OPC_TICK,  16'h7FFF, rand16(), 8'hFF);
      send_item(OPC_TICK,  16'h7FFF, rand16(), 8'h00);  // top speed zero, cruise
      send_item(OPC_TICK,  16'h7FFF, rand16(), 8'h02);  // above top speed, cruise
      send_item(OPC_TICK,  16'h8000, rand16(), 8'hFF);
      send_item(OPC_START, 16'h8000, 16'h7FFF, rand8()); // longest move, forward
      send_item(OPC_TICK,  16'h8000, rand16(), 8'hFF);
      send_item(OPC_TICK,  16'h7FFF, rand16(), 8'hFF);
      send_item(OPC_START, 16'd0, 16'd10, rand8());
      send_item(OPC_TICK,  16'd0, rand16(), 8'hFF);
      send_item(OPC_TICK,  16'd50, rand16(), 8'hFF);    // goal passed
      send_item(OPC_TICK,  16'h7FFF, rand16(), rand8());
      send_item(OPC_START, 16'hFFFF, 16'hFFFE, rand8());
      send_item(OPC_TICK,  16'hFFFD, rand16(), rand8()); // passed going backward
      axis_pos = 16'hFFFD;

      // random phases, each under its own register setting
      for (int ph = 0; ph < N_PHASES; ph++) begin
         stop_sending();
         wait_for_commands();
         load_setting(ph);
         phase_end = sb.n_items + PHASE_ITEMS;
         paused    = 1'b0;
         if (ph == HOLD_PHASE) begin
            // receiver holds off while items keep coming back to back
            hold_asked++;
            wait (hold_active);
            steady = 1'b1;
            repeat (12) send_item(OPC_TICK, rand16(), rand16(), rand8());
            steady = 1'b0;
         end
         while (sb.n_items < phase_end) begin
            if (ph == PAUSE_PHASE && !paused && sb.n_items >= phase_end - PHASE_ITEMS / 2) begin
               stop_sending();
               wait_for_commands();
               paused = 1'b1;
            end
            case ($urandom_range(0, 9))
               0: begin
                  axis_pos = clamp16(int'(axis_pos) + $urandom_range(0, 40) - 20);
                  send_item(OPC_TICK, axis_pos, rand16(), rand8());
               end
               1: send_item(OPC_START, axis_pos, axis_pos, rand8());
               default: run_move();
            endcase
         end
      end

      stop_sending();
      wait_for_commands();
      repeat (16) @(posedge clock);
      $display("checked %0d speed commands from %0d items under %0d register settings",
               sb.n_results, sb.n_items, N_PHASES + 1);
      $display("moves completed %0d, starts refused %0d, braking results %0d, mismatches %0d",
               sb.n_done, sb.n_refused, sb.n_brake, sb.failures);
      if (sb.failures == 0 && sb.pending_commands.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/tppu_pkg.sv
rtl/tppu_sequencer.sv
rtl/tppu_datapath.sv
rtl/trapezoid_positioning_profiler_unit.sv
sim/trapezoid_positioning_profiler_unit_tb.sv
